// ===== rtl/http_chunked_decoder_defines.svh =====
// Assertion macros used by the checker file.
// Both sample on clk and are disabled while arst_n is low.
`ifndef HTTP_CHUNKED_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_DECODER_DEFINES_SVH

// Same-cycle implication.
`define HCD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define HCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== rtl/hcd_pkg.sv =====
package hcd_pkg;

	// reset value of the chunk size limit
	localparam logic [26:0] MAX_CHUNK_RESET = 27'd100000000;
	localparam logic [7:0]  LF_BYTE         = 8'h0A;

	// result status codes
	localparam logic [1:0] ST_CONTINUE = 2'd0;
	localparam logic [1:0] ST_DONE     = 2'd1;
	localparam logic [1:0] ST_FAILED   = 2'd2;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// classified input byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_lf;
		logic       is_hex;
		logic [3:0] hex_val;
	} item_t;

	// decoder phase, one-hot
	typedef enum logic [7:0] {
		PH_SIZE_START  = 8'b0000_0001,
		PH_SIZE_DIGITS = 8'b0000_0010,
		PH_SIZE_SKIP   = 8'b0000_0100,
		PH_DATA        = 8'b0000_1000,
		PH_DATA_TAIL   = 8'b0001_0000,
		PH_LAST_LINE   = 8'b0010_0000,
		PH_DONE        = 8'b0100_0000,
		PH_FAILED      = 8'b1000_0000
	} phase_t;

	// decode one raw byte into LF / hex digit flags
	function automatic item_t classify(input logic [7:0] c);
		item_t it;
		it.data_byte = c;
		it.is_lf     = (c == LF_BYTE);
		it.is_hex    = 1'b1;
		it.hex_val   = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			it.hex_val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			it.hex_val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			it.hex_val = 4'(c - 8'h37);
		end else begin
			it.is_hex = 1'b0;
		end
		return it;
	endfunction

endpackage

// ===== rtl/hcd_front.sv =====
module hcd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     data_byte,
	output logic           push,
	output hcd_pkg::item_t push_item,
	input  logic           push_ready
);
	import hcd_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	// take a new byte whenever the stage is empty or draining this cycle
	assign in_ready  = !valid_s1 || push_ready;
	assign accept    = in_valid && in_ready;
	assign push      = valid_s1 && push_ready;
	assign push_item = item_s1;

	// classify stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= classify(data_byte);
		end
	end

endmodule

// ===== rtl/hcd_fifo.sv =====
module hcd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hcd_pkg::item_t push_item,
	output logic           push_ready,
	input  logic           pop,
	output hcd_pkg::item_t pop_item,
	output logic           pop_valid
);
	import hcd_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	assign push_ready = (count_q != FIFO_CW'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];

	function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
		return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/hcd_back.sv =====
module hcd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [26:0]    cfg_wdata,
	input  logic           item_valid,
	input  hcd_pkg::item_t item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           payload_valid,
	output logic [7:0]     payload_byte,
	output logic [1:0]     status
);
	import hcd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [26:0] max_q;
	logic [26:0] size_q, size_d;
	logic [26:0] left_q, left_d;
	logic        bad_q, bad_d;
	logic        over_q, over_d;
	logic        out_valid_q;
	logic        pv_q, pv_d;
	logic [7:0]  pb_q, pb_d;
	logic [1:0]  st_q, st_d;
	logic [31:0] digit_next;
	logic        digit_over;
	logic [26:0] left_dec;

	// consume the queue head whenever the output register is free
	assign pop           = item_valid && (!out_valid_q || out_ready);
	assign out_valid     = out_valid_q;
	assign payload_valid = pv_q;
	assign payload_byte  = pb_q;
	assign status        = st_q;

	// size accumulate: value * 16 + digit, checked against the limit
	assign digit_next = {1'b0, size_q, 4'b0000} + {28'd0, item.hex_val};
	assign digit_over = digit_next > {5'd0, max_q};
	assign left_dec   = left_q - 27'd1;

	// phase update for one item
	always_comb begin
		phase_d = phase_q;
		size_d  = size_q;
		left_d  = left_q;
		bad_d   = bad_q;
		over_d  = over_q;
		pv_d    = 1'b0;
		pb_d    = 8'd0;
		st_d    = ST_CONTINUE;
		case (phase_q)
			PH_SIZE_START: begin
				if (item.is_lf) begin
					phase_d = PH_FAILED;
					st_d    = ST_FAILED;
					size_d  = '0;
					bad_d   = 1'b0;
					over_d  = 1'b0;
				end else if (!item.is_hex) begin
					bad_d   = 1'b1;
					phase_d = PH_SIZE_SKIP;
				end else begin
					phase_d = PH_SIZE_DIGITS;
					if (!over_q) begin
						if (digit_over) over_d = 1'b1;
						else            size_d = digit_next[26:0];
					end
				end
			end
			PH_SIZE_DIGITS, PH_SIZE_SKIP: begin
				if (item.is_lf) begin
					// end of the size line
					if (bad_q || over_q) begin
						phase_d = PH_FAILED;
						st_d    = ST_FAILED;
					end else if (size_q == '0) begin
						phase_d = PH_LAST_LINE;
					end else begin
						left_d  = size_q;
						phase_d = PH_DATA;
					end
					size_d = '0;
					bad_d  = 1'b0;
					over_d = 1'b0;
				end else if (phase_q == PH_SIZE_DIGITS) begin
					if (!item.is_hex) begin
						phase_d = PH_SIZE_SKIP;
					end else if (!over_q) begin
						if (digit_over) over_d = 1'b1;
						else            size_d = digit_next[26:0];
					end
				end
			end
			PH_DATA: begin
				pv_d   = 1'b1;
				pb_d   = item.data_byte;
				left_d = left_dec;
				if (left_dec == '0) phase_d = PH_DATA_TAIL;
			end
			PH_DATA_TAIL: begin
				if (item.is_lf) phase_d = PH_SIZE_START;
			end
			PH_LAST_LINE: begin
				if (item.is_lf) begin
					phase_d = PH_DONE;
					st_d    = ST_DONE;
				end
			end
			PH_DONE: begin
				st_d = ST_DONE;
			end
			default: begin
				phase_d = PH_FAILED;
				st_d    = ST_FAILED;
			end
		endcase
	end

	// decoder state and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE_START;
			size_q  <= '0;
			left_q  <= '0;
			bad_q   <= 1'b0;
			over_q  <= 1'b0;
			max_q   <= MAX_CHUNK_RESET;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (pop) begin
				phase_q <= phase_d;
				size_q  <= size_d;
				left_q  <= left_d;
				bad_q   <= bad_d;
				over_q  <= over_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pv_q <= pv_d;
			pb_q <= pb_d;
			st_q <= st_d;
		end
	end

endmodule

// ===== rtl/http_chunked_decoder.sv =====
// Path: an accepted byte passes the classify stage, the queue entry and the result
// register before out_valid rises.
// Throughput: one byte per cycle unless out_ready holds the result; the back end's
// per-byte update of phase and size (shift-add and limit compare, or a down count) sets it.
// Reset (arst_n low): phase goes to size line start, counters and queue empty,
// max_chunk_size returns to 100000000; payload registers are not cleared.
module http_chunked_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [26:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [1:0]  status
);
	import hcd_pkg::*;

	logic  push, push_ready;
	item_t push_item;
	logic  pop, pop_valid;
	item_t pop_item;

	// accept and classify
	hcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	// decoupling queue
	hcd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid)
	);

	// chunk state machine and result register
	hcd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.item_valid    (pop_valid),
		.item          (pop_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.status        (status)
	);

endmodule

// ===== rtl/hcd_checker.sv =====
`include "http_chunked_decoder_defines.svh"

module hcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        payload_valid,
	input logic [7:0]  payload_byte,
	input logic [1:0]  status
);
	import hcd_pkg::*;

	logic ended_q;
	logic failed_q;

	// remember a delivered end or failure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q  <= 1'b0;
			failed_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			if (status == ST_DONE)   ended_q  <= 1'b1;
			if (status == ST_FAILED) failed_q <= 1'b1;
		end
	end

	// end and failure are sticky
	`HCD_ASSERT_NOW(a_end_sticky, out_valid && ended_q, status == ST_DONE && !payload_valid)
	`HCD_ASSERT_NOW(a_fail_sticky, out_valid && failed_q, status == ST_FAILED && !payload_valid)
	// payload only while the body continues, zero byte otherwise
	`HCD_ASSERT_NOW(a_payload_status, out_valid && payload_valid, status == ST_CONTINUE)
	`HCD_ASSERT_NOW(a_idle_byte, out_valid && !payload_valid, payload_byte == 8'd0)
	// a stalled result holds
	`HCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(payload_valid) && $stable(payload_byte) && $stable(status))

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (.*);
